[src/ba_pkg.sv]
// ----------------------------------------------------------------------------
// ba_pkg
// Shared types, codes and tree-layout helpers for the buddy allocator.
// ----------------------------------------------------------------------------
package ba_pkg;

    // pool geometry
    localparam int LOG_UNITS = 10;
    localparam int UNITS     = 1 << LOG_UNITS;
    localparam int FR_W      = 32;                 // free bits per row
    localparam int ROW_SH    = LOG_UNITS - 5;      // last order that fills whole rows

    // operation codes
    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_QUERY = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOSPACE   = 2'd1;
    localparam logic [1:0] ST_BADHANDLE = 2'd2;

    typedef struct packed {
        t_func       func;
        logic [10:0] req_size;
        logic [9:0]  handle;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_start;
        logic [10:0] block_size;
    } t_out;

    typedef logic [3:0] t_ord;

    // row of the free memory where the bitmap of order k begins
    function automatic logic [6:0] row_base(input t_ord k);
        int r;
        if (int'(k) <= ROW_SH) begin
            r = (1 << (ROW_SH + 1)) - (1 << (ROW_SH + 1 - int'(k)));
        end else begin
            r = (1 << (ROW_SH + 1)) - 2 + int'(k) - ROW_SH;
        end
        return 7'(r);
    endfunction

    // rows used by the bitmap of order k
    function automatic logic [5:0] rows_of(input t_ord k);
        int r;
        if (int'(k) <= ROW_SH) begin
            r = 1 << (ROW_SH - int'(k));
        end else begin
            r = 1;
        end
        return 6'(r);
    endfunction

    // row and bit of the tree node of order k starting at slot s
    function automatic logic [6:0] node_row(input t_ord k, input logic [9:0] s);
        logic [9:0] j;
        j = s >> k;
        return row_base(k) + 7'(j >> 5);
    endfunction

    function automatic logic [4:0] node_bit(input t_ord k, input logic [9:0] s);
        logic [9:0] j;
        j = s >> k;
        return j[4:0];
    endfunction

    localparam int FR_DEPTH = int'(row_base(t_ord'(LOG_UNITS))) + 1;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SIZE, S_SRCH_RD, S_SRCH_CHK, S_SPLIT_RD, S_SPLIT_WR,
        S_ALLOC_DONE, S_ORD_RD, S_ORD_CHK, S_MERGE_RD, S_MERGE_CHK, S_SET_RD,
        S_SET_WR, S_RESULT
    } t_state;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_SIZE, CMD_SRCH_RD, CMD_SRCH_CHK,
        CMD_SPLIT_RD, CMD_SPLIT_WR, CMD_ALLOC_DONE, CMD_ORD_RD, CMD_ORD_CHK,
        CMD_MERGE_RD, CMD_MERGE_CHK, CMD_SET_RD, CMD_SET_WR, CMD_PUSH
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        t_func in_func;
        t_func cur_func;
        logic  clr_done;
        logic  too_big;
        logic  hit;
        logic  exhausted;
        logic  split_more;
        logic  ord_bad;
        logic  merge_start;
        logic  merge_hit;
        logic  merge_more;
        logic  out_ready;
    } t_stat;

endpackage

[src/buddy_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_allocator
// Buddy allocator over 1024 slots: allocate, free and query by block handle.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall, beat carries func, req_size, handle.
// Output channel: o_out_valid / i_out_stall, one result beat per input beat,
// carrying status, block_start and block_size, in input order.
// One item is worked on at a time; the next input beat is taken once the
// result sits in the output register, even while that register is stalled.
// Allocate reads and checks bitmap rows in turn, then updates one per split;
// the scan of 32-bit free-bitmap rows through one memory port dominates
// (up to 68 rows on a full pool). A too-large request skips the scan. Free
// checks one buddy per merge level (up to 10 levels), then sets the freed
// node; query and bad handles only read the order memory.
// After reset the block clears both memories with o_in_stall high, then
// leaves only the whole-pool block free.
// A stalled result beat holds in the output register; the block finishes
// the next item and then waits for that register to drain.
// ----------------------------------------------------------------------------
module buddy_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  ba_pkg::t_in  i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output ba_pkg::t_out o_out_data
);
    import ba_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    ba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    // memories and arithmetic
    ba_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );
endmodule

[src/ba_ram.sv]
// ----------------------------------------------------------------------------
// ba_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/ba_datapath.sv]
// ----------------------------------------------------------------------------
// ba_datapath
// Free bitmap and order memories, search and merge registers, result register.
// ----------------------------------------------------------------------------
module ba_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ba_pkg::t_cmd  i_cmd,
    input  ba_pkg::t_in   i_in_data,
    input  logic          i_out_stall,
    output ba_pkg::t_stat o_stat,
    output logic          o_out_valid,
    output ba_pkg::t_out  o_out_data
);
    import ba_pkg::*;

    localparam int FR_AW = $clog2(FR_DEPTH);
    localparam int OR_AW = $clog2(UNITS);

    t_func       r_func;
    logic [10:0] r_req;
    logic [9:0]  r_handle;
    t_ord        r_k, r_lg, r_k0;
    logic [4:0]  r_row;
    logic [9:0]  r_start, r_idx;
    logic [9:0]  r_clr;
    t_out        r_res, r_out;
    logic        r_out_valid;

    logic             fr_we;
    logic [FR_AW-1:0] fr_waddr, fr_raddr;
    logic [FR_W-1:0]  fr_wdata, fr_q;
    logic             or_we;
    logic [OR_AW-1:0] or_waddr;
    logic [4:0]       or_wdata, or_q;

    logic [10:0] req1;
    t_ord        lg;
    logic        too_big;
    logic [4:0]  pos;
    logic        hit, last_row, exhausted;
    logic [9:0]  found;
    t_ord        k_dn;
    logic [9:0]  split_rs, split_ws, buddy;
    logic [6:0]  srch_row;
    logic        merge_hit;
    logic        ord_bad;
    t_ord        k0;
    logic        out_ready;

    ba_ram #(.WIDTH(FR_W), .DEPTH(FR_DEPTH)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (fr_we),
        .i_waddr(fr_waddr),
        .i_wdata(fr_wdata),
        .i_raddr(fr_raddr),
        .o_rdata(fr_q)
    );

    ba_ram #(.WIDTH(5), .DEPTH(UNITS)) u_order_ram (
        .i_clk  (i_clk),
        .i_we   (or_we),
        .i_waddr(or_waddr),
        .i_wdata(or_wdata),
        .i_raddr(r_handle),
        .o_rdata(or_q)
    );

    // request order, rounded up
    always_comb begin
        req1    = (r_req == 11'd0) ? 11'd1 : r_req;
        too_big = req1 > 11'(UNITS);
        lg      = 4'd11;
        for (int i = 11; i >= 0; i--) begin
            if ((12'd1 << i) >= {1'b0, req1}) begin
                lg = 4'(i);
            end
        end
    end

    // lowest set bit of the row being searched
    always_comb begin
        pos = 5'd0;
        for (int i = FR_W - 1; i >= 0; i--) begin
            if (fr_q[i]) begin
                pos = 5'(i);
            end
        end
    end

    // node addressing
    always_comb begin
        hit       = fr_q != '0;
        last_row  = (6'(r_row) == rows_of(r_k) - 6'd1);
        exhausted = !hit && last_row && (r_k == t_ord'(LOG_UNITS));
        found     = 10'({r_row, pos} << r_k);
        k_dn      = r_k - 4'd1;
        split_rs  = r_start | (10'd1 << k_dn);
        split_ws  = r_start | (10'd1 << r_k);
        buddy     = r_idx ^ (10'd1 << r_k);
        srch_row  = row_base(r_k) + 7'(r_row);
        merge_hit = fr_q[node_bit(r_k, buddy)];
        ord_bad   = (or_q == 5'd0) || (or_q > 5'(LOG_UNITS + 1));
        k0        = 4'(or_q - 5'd1);
        out_ready = !r_out_valid || !i_out_stall;
    end

    // free memory read address
    always_comb begin
        case (i_cmd)
            CMD_SRCH_RD:  fr_raddr = FR_AW'(srch_row);
            CMD_SPLIT_RD: fr_raddr = FR_AW'(node_row(k_dn, split_rs));
            CMD_MERGE_RD: fr_raddr = FR_AW'(node_row(r_k, buddy));
            CMD_SET_RD:   fr_raddr = FR_AW'(node_row(r_k, r_idx));
            default:      fr_raddr = '0;
        endcase
    end

    // free memory write
    always_comb begin
        fr_we    = 1'b0;
        fr_waddr = '0;
        fr_wdata = '0;
        case (i_cmd)
            CMD_CLEAR: begin
                fr_we    = 11'(r_clr) < 11'(FR_DEPTH);
                fr_waddr = r_clr[FR_AW-1:0];
                fr_wdata = (7'(r_clr) == row_base(t_ord'(LOG_UNITS))
                            && r_clr[9:7] == 3'd0) ? FR_W'(1) : '0;
            end
            CMD_SRCH_CHK: begin
                fr_we    = hit;
                fr_waddr = FR_AW'(srch_row);
                fr_wdata = fr_q & ~(FR_W'(1) << pos);
            end
            CMD_SPLIT_WR: begin
                fr_we    = 1'b1;
                fr_waddr = FR_AW'(node_row(r_k, split_ws));
                fr_wdata = fr_q | (FR_W'(1) << node_bit(r_k, split_ws));
            end
            CMD_MERGE_CHK: begin
                fr_we    = merge_hit;
                fr_waddr = FR_AW'(node_row(r_k, buddy));
                fr_wdata = fr_q & ~(FR_W'(1) << node_bit(r_k, buddy));
            end
            CMD_SET_WR: begin
                fr_we    = 1'b1;
                fr_waddr = FR_AW'(node_row(r_k, r_idx));
                fr_wdata = fr_q | (FR_W'(1) << node_bit(r_k, r_idx));
            end
            default: begin
                fr_we = 1'b0;
            end
        endcase
    end

    // order memory write
    always_comb begin
        or_we    = 1'b0;
        or_waddr = '0;
        or_wdata = '0;
        case (i_cmd)
            CMD_CLEAR: begin
                or_we    = 1'b1;
                or_waddr = r_clr;
            end
            CMD_ALLOC_DONE: begin
                or_we    = 1'b1;
                or_waddr = r_start;
                or_wdata = 5'(r_lg) + 5'd1;
            end
            CMD_ORD_CHK: begin
                or_we    = !ord_bad && (r_func == FN_FREE);
                or_waddr = r_handle;
            end
            default: begin
                or_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_lg        <= '0;
        end else begin
            if (i_cmd == CMD_CLEAR) begin
                r_clr <= r_clr + 10'd1;
            end
            if (i_cmd == CMD_PUSH && out_ready) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_SIZE: begin
                    // an oversized request leaves the order registers alone
                    if (!too_big) begin
                        r_k  <= lg;
                        r_lg <= lg;
                    end
                end
                CMD_SRCH_CHK: begin
                    if (!hit && last_row && !exhausted) begin
                        r_k <= r_k + 4'd1;
                    end
                end
                CMD_SPLIT_RD: r_k <= k_dn;
                CMD_ORD_CHK: begin
                    if (!ord_bad && r_func == FN_FREE) begin
                        r_k <= k0;
                    end
                end
                CMD_MERGE_CHK: begin
                    if (merge_hit) begin
                        r_k <= r_k + 4'd1;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_PUSH && out_ready) begin
            r_out <= r_res;
        end
        case (i_cmd)
            CMD_LOAD: begin
                r_func   <= i_in_data.func;
                r_req    <= i_in_data.req_size;
                r_handle <= i_in_data.handle;
                r_res    <= '0;
            end
            CMD_SIZE: begin
                r_row <= '0;
                if (too_big) begin
                    r_res <= '{status: ST_NOSPACE, block_start: '0, block_size: '0};
                end
            end
            CMD_SRCH_CHK: begin
                if (hit) begin
                    r_start <= found;
                end else if (exhausted) begin
                    r_res <= '{status: ST_NOSPACE, block_start: '0, block_size: '0};
                end else if (last_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 5'd1;
                end
            end
            CMD_ALLOC_DONE: begin
                r_res <= '{status: ST_OK, block_start: r_start,
                           block_size: 11'd1 << r_lg};
            end
            CMD_ORD_CHK: begin
                if (ord_bad) begin
                    r_res <= '{status: ST_BADHANDLE, block_start: '0, block_size: '0};
                end else if (r_func == FN_QUERY) begin
                    r_res <= '{status: ST_OK, block_start: r_handle,
                               block_size: 11'd1 << k0};
                end else begin
                    r_k0  <= k0;
                    r_idx <= r_handle;
                end
            end
            CMD_MERGE_CHK: begin
                if (merge_hit) begin
                    r_idx <= r_idx & ~(10'd1 << r_k);
                end
            end
            CMD_SET_WR: begin
                r_res <= '{status: ST_OK, block_start: r_handle,
                           block_size: 11'd1 << r_k0};
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.in_func     = i_in_data.func;
        o_stat.cur_func    = r_func;
        o_stat.clr_done    = r_clr == '1;
        o_stat.too_big     = too_big;
        o_stat.hit         = hit;
        o_stat.exhausted   = exhausted;
        o_stat.split_more  = r_k > r_lg;
        o_stat.ord_bad     = ord_bad;
        o_stat.merge_start = k0 < t_ord'(LOG_UNITS);
        o_stat.merge_hit   = merge_hit;
        o_stat.merge_more  = (r_k + 4'd1) < t_ord'(LOG_UNITS);
        o_stat.out_ready   = out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // order register never leaves the tree
    ast_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= t_ord'(LOG_UNITS))
        else $error("order register out of range");

    // an allocation reports the block size of its rounded order
    ast_alloc_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_ALLOC_DONE |=> r_res.status == ST_OK
            && r_res.block_size == (11'd1 << r_lg))
        else $error("allocation result mismatch");

    // a completed free always reports success
    ast_free_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_SET_WR |=> r_res.status == ST_OK)
        else $error("free result not ok");
endmodule

[src/ba_ctrl.sv]
// ----------------------------------------------------------------------------
// ba_ctrl
// Sequencer for clearing, allocate search and split, free merge, query, and result.
// ----------------------------------------------------------------------------
module ba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ba_pkg::t_stat i_stat,
    output ba_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import ba_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_stat.clr_done) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_stat.in_func)
                        FN_ALLOC: n_state = S_SIZE;
                        FN_FREE:  n_state = S_ORD_RD;
                        FN_QUERY: n_state = S_ORD_RD;
                        default:  n_state = S_RESULT;
                    endcase
                end
            end
            S_SIZE: n_state = i_stat.too_big ? S_RESULT : S_SRCH_RD;
            S_SRCH_RD: n_state = S_SRCH_CHK;
            S_SRCH_CHK: begin
                if (i_stat.hit) begin
                    n_state = i_stat.split_more ? S_SPLIT_RD : S_ALLOC_DONE;
                end else if (i_stat.exhausted) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SPLIT_RD: n_state = S_SPLIT_WR;
            S_SPLIT_WR: n_state = i_stat.split_more ? S_SPLIT_RD : S_ALLOC_DONE;
            S_ALLOC_DONE: n_state = S_RESULT;
            S_ORD_RD: n_state = S_ORD_CHK;
            S_ORD_CHK: begin
                if (i_stat.ord_bad || i_stat.cur_func == FN_QUERY) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = i_stat.merge_start ? S_MERGE_RD : S_SET_RD;
                end
            end
            S_MERGE_RD: n_state = S_MERGE_CHK;
            S_MERGE_CHK: begin
                n_state = (i_stat.merge_hit && i_stat.merge_more) ? S_MERGE_RD : S_SET_RD;
            end
            S_SET_RD: n_state = S_SET_WR;
            S_SET_WR: n_state = S_RESULT;
            S_RESULT: if (i_stat.out_ready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_stall = r_state != S_IDLE;
        case (r_state)
            S_CLEAR:      o_cmd = CMD_CLEAR;
            S_IDLE:       o_cmd = i_in_valid ? CMD_LOAD : CMD_NONE;
            S_SIZE:       o_cmd = CMD_SIZE;
            S_SRCH_RD:    o_cmd = CMD_SRCH_RD;
            S_SRCH_CHK:   o_cmd = CMD_SRCH_CHK;
            S_SPLIT_RD:   o_cmd = CMD_SPLIT_RD;
            S_SPLIT_WR:   o_cmd = CMD_SPLIT_WR;
            S_ALLOC_DONE: o_cmd = CMD_ALLOC_DONE;
            S_ORD_RD:     o_cmd = CMD_ORD_RD;
            S_ORD_CHK:    o_cmd = CMD_ORD_CHK;
            S_MERGE_RD:   o_cmd = CMD_MERGE_RD;
            S_MERGE_CHK:  o_cmd = CMD_MERGE_CHK;
            S_SET_RD:     o_cmd = CMD_SET_RD;
            S_SET_WR:     o_cmd = CMD_SET_WR;
            S_RESULT:     o_cmd = CMD_PUSH;
            default:      o_cmd = CMD_NONE;
        endcase
    end
endmodule

[test/buddy_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_checker
// Watches both channels of the buddy allocator, keeps its own copy of the
// free tree and the per-slot block orders, predicts each result beat and
// compares it field by field, in order, with what the block returns.
// ----------------------------------------------------------------------------
module buddy_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_stall,
    input  ba_pkg::t_in  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_stall,
    input  ba_pkg::t_out i_out_data,
    output int           o_errors,
    output int           o_pending
);
    import ba_pkg::*;

    localparam int NODES = 2 * UNITS - 1;

    // predicted state
    logic       tree_free [NODES];
    logic [4:0] slot_order [UNITS];
    t_out       want_q [$];
    int         errors;
    int         pending;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic int tree_node(input int k, input int s);
        return ((1 << (LOG_UNITS - k)) - 1) + (s >> k);
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] exp_v);
        $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
        errors++;
    endtask

    // allocate: lowest-index free block of the smallest fitting order
    function automatic t_out predict_alloc(input logic [10:0] req);
        t_out r;
        int   lg, need, k, j, s;
        r = '0;
        need = (req == 0) ? 1 : int'(req);
        lg = 0;
        while (lg < 12 && (1 << lg) < need) lg++;
        r.status = ST_NOSPACE;
        if (lg > LOG_UNITS) return r;
        for (k = lg; k <= LOG_UNITS; k++) begin
            for (j = 0; j < (UNITS >> k); j++) begin
                s = j << k;
                if (tree_free[tree_node(k, s)]) begin
                    tree_free[tree_node(k, s)] = 1'b0;
                    while (k > lg) begin
                        k--;
                        tree_free[tree_node(k, s + (1 << k))] = 1'b1;
                    end
                    slot_order[s] = 5'(lg + 1);
                    r.status      = ST_OK;
                    r.block_start = 10'(s);
                    r.block_size  = 11'(1 << lg);
                    return r;
                end
            end
        end
        return r;
    endfunction

    // free: release and merge with free buddies upward
    function automatic t_out predict_free(input logic [9:0] h);
        t_out r;
        int   k, k0, idx, bud;
        r = '0;
        if (slot_order[h] == 0) begin
            r.status = ST_BADHANDLE;
            return r;
        end
        k0 = int'(slot_order[h]) - 1;
        slot_order[h] = '0;
        k = k0;
        idx = int'(h);
        while (k < LOG_UNITS) begin
            bud = idx ^ (1 << k);
            if (!tree_free[tree_node(k, bud)]) break;
            tree_free[tree_node(k, bud)] = 1'b0;
            idx &= ~(1 << k);
            k++;
        end
        tree_free[tree_node(k, idx)] = 1'b1;
        r.status      = ST_OK;
        r.block_start = h;
        r.block_size  = 11'(1 << k0);
        return r;
    endfunction

    function automatic t_out predict_beat(input t_in b);
        t_out r;
        r = '0;
        case (b.func)
            FN_ALLOC: r = predict_alloc(b.req_size);
            FN_FREE:  r = predict_free(b.handle);
            FN_QUERY: begin
                if (slot_order[b.handle] == 0) begin
                    r.status = ST_BADHANDLE;
                end else begin
                    r.block_start = b.handle;
                    r.block_size  = 11'(1 << (int'(slot_order[b.handle]) - 1));
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // watch both channels
    always @(posedge i_clk) begin
        t_out exp_v;
        if (!i_rst_n) begin
            foreach (tree_free[n]) tree_free[n] = 1'b0;
            foreach (slot_order[n]) slot_order[n] = '0;
            tree_free[tree_node(LOG_UNITS, 0)] = 1'b1;
            want_q.delete();
            errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (want_q.size() == 0) begin
                    report("extra result beat", 32'd1, 32'd0);
                end else begin
                    exp_v = want_q[0];
                    want_q.delete(0);
                    if (i_out_data.status !== exp_v.status)
                        report("status", 32'(i_out_data.status), 32'(exp_v.status));
                    if (i_out_data.block_start !== exp_v.block_start)
                        report("block_start", 32'(i_out_data.block_start),
                               32'(exp_v.block_start));
                    if (i_out_data.block_size !== exp_v.block_size)
                        report("block_size", 32'(i_out_data.block_size),
                               32'(exp_v.block_size));
                end
            end
            if (i_in_valid && !i_in_stall)
                want_q.insert(want_q.size(), predict_beat(i_in_data));
        end
        pending = want_q.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the buddy allocator: directed edge cases, then random mixes of
// allocate, free, query and unused-func beats that mostly target live blocks, with random gaps
// on both sides. The checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
    import ba_pkg::*;

    localparam int RAND_BEATS = 1430;
    localparam int IDLE_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;
    int   errors;
    int   pending;
    int   quiet_cycles;
    bit   calm;
    logic [9:0] handles [$];

    buddy_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    buddy_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_data (out_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    function automatic bit handles_has(input logic [9:0] h);
        foreach (handles[n]) if (handles[n] == h) return 1'b1;
        return 1'b0;
    endfunction

    // remember handles of granted blocks for later free and query beats
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall && out_data.status == ST_OK
                && out_data.block_size != 0 && !handles_has(out_data.block_start))
            handles.insert(handles.size(), out_data.block_start);
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // valid drops only in idle cycles, so it is written once per edge
    task automatic send_beat(input t_func f, input logic [10:0] sz, input logic [9:0] h);
        while (!calm && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        in_data.func     <= f;
        in_data.req_size <= sz;
        in_data.handle   <= h;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [9:0] live_handle();
        int n;
        if (handles.size() == 0) return 10'($urandom_range(1023));
        n = $urandom_range(handles.size() - 1);
        return handles[n];
    endfunction

    initial begin
        logic [10:0] sz;
        logic [9:0]  h;
        int          pick;
        int          n;
        calm     = 1'b0;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, every error case
        send_beat(FN_ALLOC, 11'd1024, 10'd0);
        send_beat(FN_ALLOC, 11'd1, 10'd0);
        send_beat(FN_QUERY, 11'd0, 10'd0);
        send_beat(FN_FREE, 11'd0, 10'd0);
        send_beat(FN_FREE, 11'd0, 10'd0);
        send_beat(FN_ALLOC, 11'd1025, 10'd0);
        send_beat(FN_ALLOC, 11'h7ff, 10'h3ff);
        send_beat(FN_ALLOC, 11'd0, 10'd0);
        send_beat(FN_ALLOC, 11'd3, 10'd0);
        send_beat(FN_ALLOC, 11'd512, 10'd0);
        send_beat(FN_ALLOC, 11'd512, 10'd0);
        send_beat(FN_QUERY, 11'h7ff, 10'd4);
        send_beat(FN_QUERY, 11'd0, 10'd5);
        send_beat(FN_FREE, 11'd0, 10'h3ff);
        send_beat(FN_QUERY, 11'd0, 10'h3ff);
        send_beat(FN_NONE, 11'h7ff, 10'h3ff);
        send_beat(FN_FREE, 11'd0, 10'd512);
        send_beat(FN_FREE, 11'd0, 10'd4);
        send_beat(FN_FREE, 11'd0, 10'd0);
        send_beat(FN_ALLOC, 11'd1024, 10'd0);
        send_beat(FN_FREE, 11'd0, 10'd0);

        // sender holds off until every result is back
        drain();
        handles.delete();

        // random mix, mostly small sizes, frees mostly on live blocks
        for (n = 0; n < RAND_BEATS; n++) begin
            calm = (n >= 300 && n < 450);
            // keep handle list trimmed to the newest 64 entries, live or not
            pick = $urandom_range(99);
            sz = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                          : 11'($urandom_range(33));
            h = ($urandom_range(4) == 0) ? 10'($urandom) : live_handle();
            if (pick < 45) begin
                send_beat(FN_ALLOC, sz, h);
            end else if (pick < 80) begin
                send_beat(FN_FREE, sz, h);
            end else if (pick < 96) begin
                send_beat(FN_QUERY, sz, h);
            end else begin
                send_beat(FN_NONE, sz, h);
            end
            if (handles.size() > 64) handles.delete(0);
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/ba_pkg.sv
src/ba_ram.sv
src/ba_datapath.sv
src/ba_ctrl.sv
src/buddy_allocator.sv
test/buddy_checker.sv
test/tb.sv
